// ===== rtl/rgbe_scanline_rle_decoder_assert.svh =====
// Assertion macros for the RGBE scanline decoder
`ifndef RGBE_SCANLINE_RLE_DECODER_ASSERT_SVH
`define RGBE_SCANLINE_RLE_DECODER_ASSERT_SVH
`define RGBE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbe decoder check failed");
`define RGBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbe decoder check failed");
`endif

// ===== rtl/rgbe_pkg.sv =====
// ---------------------------------------------------------------------------
// rgbe_pkg
// Shared types and constants for the RGBE scanline decoder.
// ---------------------------------------------------------------------------
`default_nettype none
package rgbe_pkg;
  localparam int MaxWidth = 4096;
  localparam int PosW     = 13;
  localparam int AddrW    = 14;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] exponent;
    logic       line_end;
    logic       image_end;
    logic [2:0] status;
  } out_item_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BUSY  = 3'd1;
  localparam logic [2:0] ST_WIDTH = 3'd2;
  localparam logic [2:0] ST_COUNT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER, PH_TOKEN, PH_RUNVAL, PH_LITERAL, PH_FLAT
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_READ, S_WAIT, S_OUT
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;  // evaluate the held item and update decode state
    logic run_step;   // write one run byte
    logic start_read; // issue store read for drain
    logic load_pix;   // capture read data into the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_more;  // run still has bytes to write
    logic is_read;   // held item is a pixel request with a pixel pending
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/rgbe_ctrl.sv =====
// ---------------------------------------------------------------------------
// rgbe_ctrl
// Sequencer: accept, run fill, store read, result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none
module rgbe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire rgbe_pkg::sts_t sts,
  output rgbe_pkg::cmd_t     cmd
);
  import rgbe_pkg::*;
  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RUN;
      S_RUN: begin
        if (sts.is_read)        state_nxt = S_READ;
        else if (!sts.run_more) state_nxt = S_OUT;
      end
      S_READ: state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // take_item is raised in S_IDLE, so the item is evaluated at the edge that enters S_RUN
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_item = in_valid;
      end
      S_RUN:  cmd.run_step   = sts.run_more;
      S_READ: cmd.start_read = 1'b1;
      S_WAIT: cmd.load_pix   = 1'b1;
      S_OUT:  out_valid      = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/rgbe_dp.sv =====
// ---------------------------------------------------------------------------
// rgbe_dp
// Decode state, line store and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module rgbe_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rgbe_pkg::in_item_t in_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire rgbe_pkg::cmd_t     cmd,
  output rgbe_pkg::sts_t          sts,
  output rgbe_pkg::out_item_t     out_data
);
  import rgbe_pkg::*;

  logic [7:0] rd_data [4];

  logic [14:0] width_r;
  logic [15:0] height_r;
  phase_t      phase_r;
  logic [1:0]  plane_r;
  logic [15:0] pos_r;      // wide enough for position + run overshoot
  logic [7:0]  lit_r;
  logic [23:0] hdr_r;
  logic        flat_r, err_r;
  logic [15:0] lines_r;
  logic [PosW-1:0] drain_r;
  logic [PosW-1:0] pend_r;
  logic [7:0]  run_val_r;
  logic        run_act_r, is_read_r, le_r, ie_r;
  out_item_t   res_r;

  // store write port
  logic        wr_en;
  logic [1:0]  wr_plane;
  logic [15:0] wr_pos;
  logic [7:0]  wr_val;
  logic [3:0]  wr_flat;   // flat pixel writes all planes at column 0
  logic [7:0]  flat_b [4];

  // one bank per plane: one write and one registered read per cycle
  for (genvar p = 0; p < 4; p++) begin : g_plane
    logic [7:0] mem [MaxWidth];
    logic [7:0] rd_r;

    always_ff @(posedge clk) begin
      if (wr_flat[p])
        mem[{(AddrW-2){1'b0}}] <= flat_b[p];
      else if (wr_en && wr_plane == 2'(p) && wr_pos < 16'(MaxWidth))
        mem[wr_pos[AddrW-3:0]] <= wr_val;
      if (cmd.start_read)
        rd_r <= mem[drain_r[AddrW-3:0]];
    end

    assign rd_data[p] = rd_r;
  end

  logic done_img;
  assign done_img = (lines_r >= height_r) || (width_r == '0);

  logic [15:0] room;
  assign room = (pos_r < {1'b0, width_r}) ? ({1'b0, width_r} - pos_r) : '0;

  assign sts.run_more = run_act_r;
  assign sts.is_read  = is_read_r;

  always_comb begin
    wr_en    = run_act_r;
    wr_plane = plane_r;
    wr_pos   = pos_r;
    wr_val   = run_val_r;
    wr_flat  = '0;
    flat_b[0] = hdr_r[23:16];
    flat_b[1] = hdr_r[15:8];
    flat_b[2] = hdr_r[7:0];
    flat_b[3] = in_data.data_byte;
    if (cmd.take_item && !in_data.mode && pend_r == '0 && !err_r && !done_img) begin
      if ((phase_r == PH_HEADER || phase_r == PH_FLAT) && lit_r == 8'd3) begin
        if (phase_r == PH_FLAT || flat_r || width_r < 15'd8 || hdr_r[23:16] != 8'd2 ||
            hdr_r[15:8] != 8'd2 || hdr_r[7])
          wr_flat = 4'hF;
      end else if (phase_r == PH_LITERAL) begin
        wr_en  = 1'b1;
        wr_val = in_data.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= '0; height_r <= '0; phase_r <= PH_HEADER; plane_r <= '0;
      pos_r <= '0; lit_r <= '0; hdr_r <= '0; flat_r <= 1'b0; err_r <= 1'b0;
      lines_r <= '0; drain_r <= '0; pend_r <= '0; run_act_r <= 1'b0;
      is_read_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) width_r  <= cfg_wdata[14:0];
        else                        height_r <= cfg_wdata;
      end
      is_read_r <= cmd.take_item && in_data.mode && (pend_r != '0);
      if (cmd.take_item) begin
        res_r <= '0;
        if (in_data.mode) begin
          if (pend_r == '0) begin
            res_r.status <= (err_r || done_img) ? ST_DONE : ST_OK;
          end else begin
            le_r <= flat_r ? (pos_r + 16'd1 >= {1'b0, width_r}) : (pend_r == PosW'(1));
            ie_r <= (flat_r ? (pos_r + 16'd1 >= {1'b0, width_r}) : (pend_r == PosW'(1)))
                    && ({1'b0, lines_r} + 17'd1 >= {1'b0, height_r});
          end
        end else if (pend_r != '0) begin
          res_r.status <= ST_BUSY;
        end else if (err_r || done_img) begin
          res_r.status <= ST_DONE;
        end else begin
          unique case (phase_r)
            PH_HEADER, PH_FLAT: begin
              if (lit_r < 8'd3) begin
                hdr_r <= {hdr_r[15:0], in_data.data_byte};
                lit_r <= lit_r + 8'd1;
              end else begin
                lit_r <= '0;
                hdr_r <= '0;
                if (wr_flat != '0) begin
                  flat_r <= 1'b1; phase_r <= PH_FLAT; drain_r <= '0;
                  pend_r <= PosW'(1);
                end else if ({hdr_r[7:0], in_data.data_byte} != {1'b0, width_r} ||
                             width_r > 15'(MaxWidth)) begin
                  err_r <= 1'b1; res_r.status <= ST_WIDTH;
                end else begin
                  plane_r <= '0; pos_r <= '0; phase_r <= PH_TOKEN;
                end
              end
            end
            PH_TOKEN: begin
              if (in_data.data_byte > 8'd128) begin
                if (16'(in_data.data_byte - 8'd128) > room) begin
                  err_r <= 1'b1; res_r.status <= ST_COUNT;
                end else begin
                  lit_r <= in_data.data_byte - 8'd128; phase_r <= PH_RUNVAL;
                end
              end else if (in_data.data_byte == '0 || 16'(in_data.data_byte) > room) begin
                err_r <= 1'b1; res_r.status <= ST_COUNT;
              end else begin
                lit_r <= in_data.data_byte; phase_r <= PH_LITERAL;
              end
            end
            PH_RUNVAL: begin
              run_val_r <= in_data.data_byte;
              run_act_r <= (lit_r != '0);
              if (lit_r == '0) begin
                pos_r <= pos_r; // empty run cannot occur; handled by plane step
              end
            end
            PH_LITERAL: begin
              if (lit_r <= 8'd1) begin
                lit_r <= '0;
                if (pos_r + 16'd1 >= {1'b0, width_r}) begin
                  pos_r <= '0;
                  if (plane_r == 2'd3) begin
                    pend_r <= (width_r > 15'(MaxWidth)) ? PosW'(MaxWidth) : width_r[PosW-1:0];
                    drain_r <= '0; plane_r <= '0; phase_r <= PH_HEADER;
                  end else begin
                    plane_r <= plane_r + 2'd1; phase_r <= PH_TOKEN;
                  end
                end else begin
                  pos_r <= pos_r + 16'd1; phase_r <= PH_TOKEN;
                end
              end else begin
                pos_r <= pos_r + 16'd1; lit_r <= lit_r - 8'd1;
              end
            end
            default: ;
          endcase
        end
      end
      // one run byte per cycle
      if (cmd.run_step) begin
        lit_r <= lit_r - 8'd1;
        if (lit_r == 8'd1) begin
          run_act_r <= 1'b0;
          if (pos_r + 16'd1 >= {1'b0, width_r}) begin
            pos_r <= '0;
            if (plane_r == 2'd3) begin
              pend_r <= (width_r > 15'(MaxWidth)) ? PosW'(MaxWidth) : width_r[PosW-1:0];
              drain_r <= '0; plane_r <= '0; phase_r <= PH_HEADER;
            end else begin
              plane_r <= plane_r + 2'd1; phase_r <= PH_TOKEN;
            end
          end else begin
            pos_r <= pos_r + 16'd1; phase_r <= PH_TOKEN;
          end
        end else begin
          pos_r <= pos_r + 16'd1;
        end
      end
      if (cmd.start_read) begin
        drain_r <= drain_r + PosW'(1);
        pend_r  <= pend_r - PosW'(1);
        if (flat_r) pos_r <= le_r ? '0 : pos_r + 16'd1;
        if (le_r) lines_r <= lines_r + 16'd1;
      end
      if (cmd.load_pix) begin
        res_r.pixel_valid <= 1'b1;
        res_r.red <= rd_data[0]; res_r.green <= rd_data[1];
        res_r.blue <= rd_data[2]; res_r.exponent <= rd_data[3];
        res_r.line_end <= le_r; res_r.image_end <= ie_r;
        res_r.status <= ST_OK;
      end
    end
  end

  assign out_data = res_r;
endmodule
`default_nettype wire

// ===== rtl/rgbe_scanline_rle_decoder.sv =====
// ---------------------------------------------------------------------------
// rgbe_scanline_rle_decoder
// Radiance adaptive RLE scanline decoder with a planar line store.
// ---------------------------------------------------------------------------
//  channel | ports                          | payload
//  input   | in_valid / in_stall / in_data  | mode, data_byte
//  result  | out_valid / out_stall / out_data | pixel and status
//  config  | cfg_we / cfg_index / cfg_wdata | image_width, image_height
//
//  Without stalls a byte item passes S_RUN and S_OUT between its accept and
//  the next accept; a run value fills its bytes in S_RUN, one line-store
//  write per cycle. A pixel request also passes S_READ and S_WAIT (store
//  read is registered). One item is in flight at a time.
//  Reset is synchronous on rst_n and clears all decode state; the line
//  store has no reset. The result is held while out_stall is high.
`default_nettype none
`include "rgbe_scanline_rle_decoder_assert.svh"
module rgbe_scanline_rle_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rgbe_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rgbe_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_wdata
);
  import rgbe_pkg::*;
  cmd_t cmd;
  sts_t sts;

  // sequence the item through evaluation, run fill and readout
  rgbe_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  // hold decode state, the line store and the result register
  rgbe_dp u_dp (
    .clk, .rst_n, .in_data, .cfg_we, .cfg_index, .cfg_wdata, .cmd, .sts,
    .out_data
  );

  `RGBE_ASSERT_IMPL(a_no_accept_busy, out_valid, in_stall)
  `RGBE_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.take_item, cmd.start_read, cmd.load_pix}))
  `RGBE_ASSERT_NEXT(a_load_then_out, cmd.load_pix, out_valid && out_data.pixel_valid)
endmodule
`default_nettype wire

// ===== test/tb_rgbe_scanline_rle_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgbe_scanline_rle_decoder
// Self-checking bench for the RGBE scanline decoder. Builds scanline byte
// streams (RLE lines of many widths, flat pixels, broken streams), predicts
// every result with a cycle-free decoder model and checks each result
// field by field under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_rgbe_scanline_rle_decoder;
  import rgbe_pkg::*;

  localparam int   HDR_MARK   = 2;
  localparam int   RUN_FLAG   = 128;
  localparam int   STORE_SIZE = 4 * MaxWidth;
  localparam int   IDLE_LIMIT = 5000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [15:0] cfg_wdata;

  rgbe_scanline_rle_decoder uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Items waiting for the driver and the decoded results they must produce
  in_item_t  byte_q[$];
  out_item_t pixel_q[$];

  int  fails;
  int  sent;
  int  idle_mode;
  int  quiet_cycles;
  logic in_taken;

  // -------------------------------------------------------------------------
  // Decoder model: own copy of registers and decode state
  // -------------------------------------------------------------------------
  int     m_width, m_rows;
  logic [7:0] m_store [0:STORE_SIZE-1];
  phase_t m_phase;
  int     m_plane, m_pos, m_count, m_hdr, m_lines, m_drain, m_pending;
  bit     m_flat, m_err;

  function automatic void store_put(int plane, int p, int v);
    if (p < MaxWidth && plane * MaxWidth + p < STORE_SIZE)
      m_store[plane * MaxWidth + p] = v[7:0];
  endfunction

  function automatic int store_get(int plane, int p);
    if (p < MaxWidth && plane * MaxWidth + p < STORE_SIZE)
      return m_store[plane * MaxWidth + p];
    return 0;
  endfunction

  function automatic bit image_finished();
    return m_lines >= m_rows || m_width == 0;
  endfunction

  // Close a plane once it is full; the fourth plane hands the line to drain
  function automatic void close_plane();
    if (m_pos >= m_width) begin
      m_pos = 0;
      if (m_plane == 3) begin
        m_pending = (m_width > MaxWidth) ? MaxWidth : m_width;
        m_drain   = 0;
        m_plane   = 0;
        m_phase   = PH_HEADER;
        return;
      end
      m_plane++;
    end
    m_phase = PH_TOKEN;
  endfunction

  function automatic logic [2:0] take_byte(int b);
    int b0, b1, b2, room, n;
    if (m_phase == PH_HEADER || m_phase == PH_FLAT) begin
      if (m_count < 3) begin
        m_hdr = ((m_hdr << 8) | b) & 'hffffff;
        m_count++;
        return ST_OK;
      end
      b0 = (m_hdr >> 16) & 'hff;
      b1 = (m_hdr >> 8) & 'hff;
      b2 = m_hdr & 'hff;
      m_count = 0;
      m_hdr = 0;
      // Anything but an RLE header, or a width under 8, drops the image into flat pixels
      if (m_phase == PH_FLAT || m_flat || m_width < 8 || b0 != HDR_MARK ||
          b1 != HDR_MARK || (b2 & RUN_FLAG) != 0) begin
        store_put(0, 0, b0);
        store_put(1, 0, b1);
        store_put(2, 0, b2);
        store_put(3, 0, b);
        m_flat = 1;
        m_phase = PH_FLAT;
        m_drain = 0;
        m_pending = 1;
        return ST_OK;
      end
      if (((b2 << 8) | b) != m_width || m_width > MaxWidth) begin
        m_err = 1;
        return ST_WIDTH;
      end
      m_plane = 0;
      m_pos = 0;
      m_phase = PH_TOKEN;
      return ST_OK;
    end
    if (m_phase == PH_TOKEN) begin
      room = (m_pos < m_width) ? m_width - m_pos : 0;
      if (b > RUN_FLAG) begin
        n = b - RUN_FLAG;
        if (n > room) begin
          m_err = 1;
          return ST_COUNT;
        end
        m_count = n;
        m_phase = PH_RUNVAL;
      end else begin
        if (b == 0 || b > room) begin
          m_err = 1;
          return ST_COUNT;
        end
        m_count = b;
        m_phase = PH_LITERAL;
      end
      return ST_OK;
    end
    if (m_phase == PH_RUNVAL) begin
      for (int i = 0; i < m_count; i++) store_put(m_plane, m_pos + i, b);
      m_pos += m_count;
      m_count = 0;
      close_plane();
      return ST_OK;
    end
    store_put(m_plane, m_pos, b);
    m_pos++;
    if (m_count > 0) m_count--;
    if (m_count == 0) close_plane();
    return ST_OK;
  endfunction

  function automatic out_item_t decode_item(in_item_t it);
    out_item_t r;
    bit le, ie;
    r = '0;
    if (!it.mode) begin
      if (m_pending > 0) r.status = ST_BUSY;
      else if (m_err || image_finished()) r.status = ST_DONE;
      else r.status = take_byte(it.data_byte);
      return r;
    end
    if (m_pending == 0) begin
      r.status = (m_err || image_finished()) ? ST_DONE : ST_OK;
      return r;
    end
    le = m_flat ? (m_pos + 1 >= m_width) : (m_pending == 1);
    ie = le && (m_lines + 1 >= m_rows);
    r.pixel_valid = 1'b1;
    r.red      = 8'(store_get(0, m_drain));
    r.green    = 8'(store_get(1, m_drain));
    r.blue     = 8'(store_get(2, m_drain));
    r.exponent = 8'(store_get(3, m_drain));
    r.line_end  = le;
    r.image_end = ie;
    r.status    = ST_OK;
    m_drain = (m_drain + 1) & 'h1fff;
    m_pending--;
    if (m_flat) m_pos = le ? 0 : m_pos + 1;
    if (le) m_lines = (m_lines + 1) & 'hffff;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Clock, driver, monitor, watchdog
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Advance the input channel at the falling edge; hold while stalled
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (byte_q.size() > 0 && !((idle_mode == 1 || idle_mode == 3) &&
          roll(idle_mode == 3 ? 26 : 47))) begin
        in_valid <= 1'b1;
        in_data  <= byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= (idle_mode == 2 || idle_mode == 3) && roll(idle_mode == 3 ? 26 : 47);
  end

  always @(posedge clk) begin
    out_item_t want;
    in_taken <= in_valid && !in_stall;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, pixel_q.size());
        $display("tb_rgbe_scanline_rle_decoder: FAIL");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fails++;
        end else begin
          want = pixel_q.pop_front();
          if (out_data.pixel_valid !== want.pixel_valid ||
              out_data.red !== want.red || out_data.green !== want.green ||
              out_data.blue !== want.blue || out_data.exponent !== want.exponent ||
              out_data.line_end !== want.line_end ||
              out_data.image_end !== want.image_end ||
              out_data.status !== want.status) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            fails++;
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stream builders
  // -------------------------------------------------------------------------
  task automatic send(bit m, int b);
    in_item_t it;
    it.mode = m;
    it.data_byte = b[7:0];
    pixel_q.push_back(decode_item(it));
    byte_q.push_back(it);
    sent++;
  endtask

  // Hold the sender until every result is in, let a run finish, then write
  task automatic wait_drained();
    while (pixel_q.size() > 0 || byte_q.size() > 0 || in_valid) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) m_width = val & 'h7fff;
    else m_rows = val & 'hffff;
  endtask

  task automatic new_image(int w, int h);
    wait_drained();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic send_header(int w);
    send(0, HDR_MARK);
    send(0, HDR_MARK);
    send(0, (w >> 8) & 'hff);
    send(0, w & 'hff);
  endtask

  task automatic drain_line(int w);
    repeat (w) begin
      if ($urandom_range(0, 15) == 0) send(0, $urandom_range(0, 255)); // refused
      send(1, $urandom_range(0, 255));
    end
  endtask

  // One RLE line with random mix of run and literal tokens
  task automatic rle_line(int w);
    int rest, n, cap;
    if ($urandom_range(0, 7) == 0) send(1, $urandom_range(0, 255)); // idle request
    send_header(w);
    for (int pl = 0; pl < 4; pl++) begin
      rest = w;
      while (rest > 0) begin
        if ($urandom_range(0, 1)) begin
          cap = (rest < 127) ? rest : 127;
          n = (w > 256) ? cap : $urandom_range(1, cap);
          send(0, RUN_FLAG + n);
          send(0, $urandom_range(0, 255));
        end else begin
          cap = (rest < 128) ? rest : 128;
          n = $urandom_range(1, cap);
          send(0, n);
          repeat (n) send(0, $urandom_range(0, 255));
        end
        rest -= n;
      end
    end
    drain_line(w);
  endtask

  task automatic noise(int cnt);
    repeat (cnt) send($urandom_range(0, 1), $urandom_range(0, 255));
  endtask

  initial begin
    int w, k, pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_wdata = '0;
    in_taken = 1'b0;
    fails = 0;
    sent = 0;
    idle_mode = 0;
    quiet_cycles = 0;
    m_width = 0; m_rows = 0;
    m_phase = PH_HEADER;
    m_plane = 0; m_pos = 0; m_count = 0; m_hdr = 0; m_flat = 0; m_lines = 0;
    m_drain = 0; m_pending = 0; m_err = 0;
    for (int i = 0; i < STORE_SIZE; i++) m_store[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Zero width: image done, bytes and requests both answer done
    new_image(0, 65535);
    send(0, 8'h00); send(0, 8'hff); send(1, 8'h00);

    // Full-size tokens: 128-byte literal, 127 run, single run, 1-byte literal
    new_image(128, m_lines + 2);
    send_header(128);
    send(0, RUN_FLAG);
    for (int i = 0; i < 128; i++) send(0, (i & 1) ? 8'hff : 8'h00);
    send(0, 255); send(0, 8'haa); send(0, RUN_FLAG + 1); send(0, 8'h55);
    for (int pl = 0; pl < 2; pl++) begin
      send(0, 255); send(0, 8'h00); send(0, 1); send(0, 8'hff);
    end
    drain_line(128);
    rle_line(128);

    // Random RLE images, idling pattern changes with each line
    while (sent < 900) begin
      k = $urandom_range(1, 3);
      w = $urandom_range(0, 3) == 0 ? 8 : $urandom_range(8, 32);
      new_image(w, m_lines + k);
      repeat (k) begin
        idle_mode = (idle_mode + 1) % 4;
        rle_line(w);
      end
    end

    // One wide line; its runs are full length, its literals random
    idle_mode = 0;
    new_image(260, m_lines + 1);
    rle_line(260);

    // Height reached: bytes and requests answer done
    new_image(20, 0);
    send(0, HDR_MARK); send(1, 0);
    new_image(32767, m_lines);
    send(0, 8'h7f); send(1, 8'hff);

    // Final part goes either to flat pixels or to a latched error
    idle_mode = 3;
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      w = $urandom_range(1, 7);
      new_image(w, m_lines + 4);
      repeat (4 * w) begin
        repeat (4) send(0, $urandom_range(0, 255));
        send(1, 0);
      end
    end else if (pick == 1) begin
      // Non-RLE first bytes at a legal width fall back to flat
      w = $urandom_range(8, 16);
      new_image(w, m_lines + 2);
      send(0, $urandom_range(3, 255));
      repeat (3) send(0, $urandom_range(0, 255));
      send(1, 0);
      repeat (2 * w - 1) begin
        repeat (4) send(0, $urandom_range(0, 255));
        send(1, 0);
      end
    end else if (pick == 2) begin
      // Header width mismatch, or a width above the store's size
      if ($urandom_range(0, 1)) begin
        new_image(32767, m_lines + 2);
        send_header(32767);
      end else begin
        w = $urandom_range(8, 40);
        new_image(w, m_lines + 2);
        send_header(w + 1);
      end
    end else begin
      // Zero count, or a count overrunning the plane
      w = $urandom_range(8, 40);
      new_image(w, m_lines + 2);
      send_header(w);
      case ($urandom_range(0, 2))
        0: send(0, 0);
        1: send(0, w + 1);
        default: send(0, RUN_FLAG + w + 1);
      endcase
    end
    noise(40);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("tb_rgbe_scanline_rle_decoder: PASS");
    end else begin
      $display("tb_rgbe_scanline_rle_decoder: FAIL");
    end
    $finish;
  end
endmodule
